// File: src/stepper_ramp_pulse_generator_assert.svh
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_assert.svh
// Assertion macros for the stepper ramp pulse generator
// ----------------------------------------------------------------------------
// each macro assumes clk_i and rst_ni in the calling scope
`ifndef STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SRPG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srpg assertion failed");

`define SRPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srpg assertion failed");

`else

`define SRPG_ASSERT_IMPL(lbl, ante, cons)
`define SRPG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/srpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_pkg
// Constants and codes of the stepper ramp pulse generator
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int POS_BITS         = 32;
  localparam int TICKS_PER_SECOND = 1000000;

  // divider width: the tick count quotient, at least as wide as a speed value
  localparam int QUO_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int DIV_W = (QUO_W > 16) ? QUO_W : 16;
  localparam int CNT_W = $clog2(DIV_W);

  localparam int PADDR_W = 5;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SET_TGT = 2'd1;
  localparam logic [1:0] OP_SET_POS = 2'd2;
  localparam logic [1:0] OP_STOP    = 2'd3;

  localparam logic [2:0] REG_BASE_SPEED = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd1;
  localparam logic [2:0] REG_ACCEL_RATE = 3'd2;
  localparam logic [2:0] REG_MAX_ACCEL  = 3'd3;
  localparam logic [2:0] REG_DOWN_TRIM  = 3'd4;

  localparam logic [15:0] RST_BASE_SPEED = 16'd100;
  localparam logic [15:0] RST_MAX_SPEED  = 16'd2000;
  localparam logic [15:0] RST_ACCEL_RATE = 16'd10;
  localparam logic [15:0] RST_MAX_ACCEL  = 16'd1000;
  localparam logic [15:0] RST_DOWN_TRIM  = 16'd0;

endpackage

// File: src/stepper_ramp_pulse_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Stepper pulse generator with an acceleration ramp and a serial divider
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command per
//   transaction: a one-microsecond tick, set target, set position or stop,
//   with position_value_i for the two set commands.
//   Output channel (out_valid_o / out_ready_i) returns exactly one result per
//   command: step pulse, direction, position, at-target, moving, up count.
//   For a tick, one shared restoring divider first forms the step period
//   from the step rate and one million ticks per second, then the ramp
//   length from the speed span, one bit per cycle. Other commands skip
//   the divider. One command is in work at a time.
//   The result sits in an output register; the next command is accepted
//   while it waits, and its result is written only once the old one is taken.
//   A stalled receiver therefore holds the block after at most one command.
//   Reset clears position, target, ramp and counters, loads register defaults.
//   Write registers over the APB port only while the block idles (unchecked).
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [31:0]            position_value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          step_pulse_o,
  output logic                          step_dir_o,
  output logic signed [31:0]            position_now_o,
  output logic                          at_target_o,
  output logic                          moving_o,
  output logic [31:0]                   up_steps_total_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srpg_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import srpg_pkg::*;

  `include "stepper_ramp_pulse_generator_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIVP = 2'd1;
  localparam logic [1:0] S_DIVN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [DIV_W-1:0] TICKS_DIV = DIV_W'(TICKS_PER_SECOND);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DIV_W - 1);

  // configuration registers
  logic [15:0] base_q, max_q, acc_rate_q, max_acc_q, trim_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= RST_BASE_SPEED;
      max_q      <= RST_MAX_SPEED;
      acc_rate_q <= RST_ACCEL_RATE;
      max_acc_q  <= RST_MAX_ACCEL;
      trim_q     <= RST_DOWN_TRIM;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BASE_SPEED: base_q     <= pwdata[15:0];
        REG_MAX_SPEED:  max_q      <= pwdata[15:0];
        REG_ACCEL_RATE: acc_rate_q <= pwdata[15:0];
        REG_MAX_ACCEL:  max_acc_q  <= pwdata[15:0];
        REG_DOWN_TRIM:  trim_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_SPEED: prdata = {16'd0, base_q};
      REG_MAX_SPEED:  prdata = {16'd0, max_q};
      REG_ACCEL_RATE: prdata = {16'd0, acc_rate_q};
      REG_MAX_ACCEL:  prdata = {16'd0, max_acc_q};
      REG_DOWN_TRIM:  prdata = {16'd0, trim_q};
      default:        prdata = 32'd0;
    endcase
  end

  // motion state
  logic signed [POS_BITS-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic [15:0] acc_q, acc_d;
  logic        motion_q, motion_d, dir_q, dir_d;
  logic [31:0] elapsed_q, elapsed_d, count_q, count_d;

  // command latch and sequencer
  logic [1:0]                 state_q, state_d;
  logic [1:0]                 op_q;
  logic signed [POS_BITS-1:0] val_q;
  logic [15:0]                rate_q;
  logic [DIV_W-1:0]           per_q;

  // shared divider
  logic [DIV_W-1:0] dv_q, dv_d;
  logic [15:0]      rm_q, rm_d, dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [16:0]      shifted, div_sub;
  logic             div_ge;

  // output register
  logic        out_valid_q, pulse_q;
  logic        fire, accept, pulse_d;

  logic [16:0] rate_sum;
  logic [15:0] rate_now, span;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign fire       = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  assign rate_sum = {1'b0, base_q} + {1'b0, acc_q};
  assign rate_now = (rate_sum > {1'b0, max_q}) ? max_q : rate_sum[15:0];
  assign span     = (rate_q > base_q) ? (rate_q - base_q) : 16'd0;

  // one restoring step per cycle
  assign shifted = {rm_q, dv_q[DIV_W-1]};
  assign div_sub = shifted - {1'b0, dsr_q};
  assign div_ge  = (shifted >= {1'b0, dsr_q});
  assign rm_d    = div_ge ? div_sub[15:0] : shifted[15:0];
  assign dv_d    = {dv_q[DIV_W-2:0], div_ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = (opcode_i == OP_TICK) ? S_DIVP : S_FIN;
      S_DIVP: if (cnt_q == CNT_LAST) state_d = S_DIVN;
      S_DIVN: if (cnt_q == CNT_LAST) state_d = S_FIN;
      S_FIN:  if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      val_q  <= position_value_i[POS_BITS-1:0];
      rate_q <= rate_now;
      dv_q   <= TICKS_DIV;
      rm_q   <= 16'd0;
      dsr_q  <= rate_now;
      cnt_q  <= '0;
    end else if (state_q == S_DIVP && cnt_q == CNT_LAST) begin
      // period done, start the ramp length division
      per_q <= dv_d;
      dv_q  <= DIV_W'(span);
      rm_q  <= 16'd0;
      dsr_q <= acc_rate_q;
      cnt_q <= '0;
    end else if (state_q == S_DIVP || state_q == S_DIVN) begin
      dv_q  <= dv_d;
      rm_q  <= rm_d;
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // tick evaluation
  logic [31:0]         period, thr, trim_ext;
  logic [POS_BITS-1:0] rem_up, rem_dn;
  logic [15:0]         needed;
  logic [16:0]         acc_sum;
  logic [15:0]         acc_next;
  logic                pos_lt, pos_gt;

  assign period   = (rate_q == 16'd0) ? '1 : 32'(per_q);
  assign trim_ext = {16'd0, trim_q};
  assign thr      = (period > trim_ext) ? (period - trim_ext) : 32'd0;
  assign needed   = (acc_rate_q == 16'd0) ? 16'd0 : dv_q[15:0];
  assign pos_lt   = (cur_q < tgt_q);
  assign pos_gt   = (cur_q > tgt_q);
  assign rem_up   = tgt_q - cur_q;
  assign rem_dn   = cur_q - tgt_q;
  assign acc_sum  = {1'b0, acc_q} + {1'b0, acc_rate_q};
  assign acc_next = (acc_sum > {1'b0, max_acc_q}) ? max_acc_q : acc_sum[15:0];

  always_comb begin
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    acc_d     = acc_q;
    motion_d  = motion_q;
    dir_d     = dir_q;
    elapsed_d = elapsed_q;
    count_d   = count_q;
    pulse_d   = 1'b0;
    if (fire) begin
      case (op_q)
        OP_SET_TGT: begin
          if (!motion_q) acc_d = 16'd0;
          tgt_d = val_q;
        end
        OP_SET_POS: cur_d = val_q;
        OP_STOP: begin
          cur_d    = tgt_q;
          motion_d = 1'b0;
        end
        OP_TICK: begin
          elapsed_d = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
          if (pos_lt) begin
            if (elapsed_d > period) begin
              elapsed_d = 32'd0;
              if (rem_up > POS_BITS'(needed)) acc_d = acc_next;
              motion_d = 1'b1;
              dir_d    = 1'b1;
              cur_d    = cur_q + POS_BITS'(1);
              count_d  = count_q + 32'd1;
              pulse_d  = 1'b1;
            end
          end else if (pos_gt) begin
            if (elapsed_d > thr) begin
              elapsed_d = 32'd0;
              if (rem_dn > POS_BITS'(needed)) acc_d = acc_next;
              motion_d = 1'b1;
              dir_d    = 1'b0;
              cur_d    = cur_q - POS_BITS'(1);
              pulse_d  = 1'b1;
            end
          end else begin
            motion_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      tgt_q       <= '0;
      acc_q       <= 16'd0;
      motion_q    <= 1'b0;
      dir_q       <= 1'b0;
      elapsed_q   <= 32'd0;
      count_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      tgt_q     <= tgt_d;
      acc_q     <= acc_d;
      motion_q  <= motion_d;
      dir_q     <= dir_d;
      elapsed_q <= elapsed_d;
      count_q   <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pulse_q <= pulse_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_pulse_o     = pulse_q;
  assign step_dir_o       = dir_q;
  assign position_now_o   = 32'(cur_q);
  assign at_target_o      = (cur_q == tgt_q);
  assign moving_o         = motion_q;
  assign up_steps_total_o = count_q;

  `SRPG_ASSERT_NEXT(a_tick_starts_div, accept && opcode_i == OP_TICK, state_q == S_DIVP)
  `SRPG_ASSERT_NEXT(a_fin_loads_out, fire, out_valid_q && state_q == S_IDLE)
  `SRPG_ASSERT_IMPL(a_pulse_moving, out_valid_o && step_pulse_o, moving_o)
  `SRPG_ASSERT_IMPL(a_busy_no_accept, state_q != S_IDLE, !in_ready_o && !accept)

endmodule
